// ----- rtl/core/crp_pkg.sv -----
// Shared types, codes and helper functions of the color ramp.
package crp_pkg;

    localparam int POS_W  = 12;
    localparam int COMP_W = 16;
    localparam int VAL_W  = 4 * COMP_W;
    localparam int TLEN_W = POS_W + 1;
    localparam int CMD_W  = 2;
    localparam int ST_W   = 2;
    localparam int NCOMP  = 5;
    localparam int COMP_IW = 3;

    localparam logic [CMD_W-1:0] CMD_PUT_COLOR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUT_ALPHA = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd3;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_FEW  = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POS = 1'b1;
    localparam logic [POS_W-1:0] MIN_POS_RESET = 12'd0;
    localparam logic [POS_W-1:0] MAX_POS_RESET = 12'd99;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  position;
        logic [COMP_W-1:0] red_in;
        logic [COMP_W-1:0] green_in;
        logic [COMP_W-1:0] blue_in;
        logic [COMP_W-1:0] alpha_in;
    } in_item_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [COMP_W-1:0] out_red;
        logic [COMP_W-1:0] out_green;
        logic [COMP_W-1:0] out_blue;
        logic [COMP_W-1:0] out_alpha;
        logic [TLEN_W-1:0] table_length;
    } out_item_t;

    // Running summary of the in-range points seen by a query scan.
    typedef struct packed {
        logic [1:0]       cnt;
        logic [VAL_W-1:0] first_val;
        logic [POS_W-1:0] last_pos;
        logic [VAL_W-1:0] last_val;
        logic [POS_W-1:0] sl_pos;
        logic [VAL_W-1:0] sl_val;
        logic             le_f;
        logic [POS_W-1:0] le_pos;
        logic [VAL_W-1:0] le_val;
        logic             gt_f;
        logic [POS_W-1:0] gt_pos;
        logic [VAL_W-1:0] gt_val;
    } trk_t;

    // The segment of the extended ramp that holds the queried position.
    typedef struct packed {
        logic [POS_W-1:0] a_pos;
        logic [VAL_W-1:0] a_val;
        logic [POS_W-1:0] b_pos;
        logic [VAL_W-1:0] b_val;
    } seg_t;

    typedef struct packed {
        logic load;
        logic put_step;
        logic put_commit;
        logic q_step;
        logic seg_load;
        logic mul;
        logic div_step;
        logic comp_store;
        logic res_load;
    } crp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] new_cmd;
        logic             put_end;
        logic             q_end;
        logic             div_last;
        logic             last_comp;
        logic             out_free;
    } crp_sts_t;

    function automatic trk_t trk_update(trk_t t, logic [POS_W-1:0] pos,
                                        logic [VAL_W-1:0] val, logic [POS_W-1:0] lo,
                                        logic [POS_W-1:0] hi, logic [POS_W-1:0] j);
        trk_t r;
        r = t;
        if (pos >= lo && pos <= hi)
        begin
            if (t.cnt == 2'd0)
                r.first_val = val;
            r.sl_pos   = t.last_pos;
            r.sl_val   = t.last_val;
            r.last_pos = pos;
            r.last_val = val;
            if (t.cnt != 2'd2)
                r.cnt = t.cnt + 2'd1;
            if (pos <= j)
            begin
                r.le_f   = 1'b1;
                r.le_pos = pos;
                r.le_val = val;
            end
            else if (!t.gt_f)
            begin
                r.gt_f   = 1'b1;
                r.gt_pos = pos;
                r.gt_val = val;
            end
        end
        return r;
    endfunction

    function automatic seg_t seg_select(trk_t t, logic [VAL_W-1:0] head_val,
                                        logic [POS_W-1:0] lo, logic [POS_W-1:0] hi,
                                        logic [POS_W-1:0] j);
        seg_t s;
        s.b_pos = hi;
        s.b_val = t.last_val;
        if (j == hi)
        begin
            // The final segment ends at max_pos; a point sitting there pairs with its predecessor.
            if (t.last_pos == hi)
            begin
                s.a_pos = t.sl_pos;
                s.a_val = t.sl_val;
            end
            else
            begin
                s.a_pos = t.last_pos;
                s.a_val = t.last_val;
            end
        end
        else
        begin
            if (t.le_f)
            begin
                s.a_pos = t.le_pos;
                s.a_val = t.le_val;
            end
            else
            begin
                s.a_pos = lo;
                s.a_val = head_val;
            end
            if (t.gt_f)
            begin
                s.b_pos = t.gt_pos;
                s.b_val = t.gt_val;
            end
        end
        return s;
    endfunction

endpackage

// ----- rtl/core/crp_ctrl.sv -----
// Sequencer that steps the datapath through puts, clears and queries.
module crp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  crp_pkg::crp_sts_t sts,
    output crp_pkg::crp_cmd_t cmd
);
    import crp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUT   = 3'd1;
    localparam logic [2:0] S_QSCAN = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;
    localparam logic [2:0] S_WB    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (sts.new_cmd) inside
                        CMD_PUT_COLOR, CMD_PUT_ALPHA: state_next = S_PUT;
                        CMD_CLEAR:                    state_next = S_WB;
                        default:                      state_next = S_QSCAN;
                    endcase
                end
            end
            S_PUT:
            begin
                if (sts.put_end)
                begin
                    cmd.put_commit = 1'b1;
                    state_next     = S_WB;
                end
                else
                    cmd.put_step = 1'b1;
            end
            S_QSCAN:
            begin
                if (sts.q_end)
                begin
                    cmd.seg_load = 1'b1;
                    state_next   = S_MUL;
                end
                else
                    cmd.q_step = 1'b1;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.comp_store = 1'b1;
                state_next     = sts.last_comp ? S_WB : S_MUL;
            end
            S_WB:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/core/crp_dpath.sv -----
// Point tables, query scan, multiplier, serial divider and output register.
module crp_dpath #(
    parameter int MAX_POINTS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  crp_pkg::in_item_t                 in_item,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [crp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crp_pkg::POS_W-1:0]         cfg_data,
    input  logic                              out_stall,
    output logic                              out_valid,
    output crp_pkg::out_item_t                out_item,
    input  crp_pkg::crp_cmd_t                 cmd,
    output crp_pkg::crp_sts_t                 sts
);
    import crp_pkg::*;

    localparam int IW = $clog2(MAX_POINTS + 1);
    localparam int IX = $clog2(MAX_POINTS);
    localparam int SW = $clog2(COMP_W);

    logic [POS_W-1:0]  min_pos_reg, max_pos_reg;
    logic [POS_W-1:0]  cpos_reg [MAX_POINTS];
    logic [VAL_W-1:0]  cval_reg [MAX_POINTS];
    logic [POS_W-1:0]  apos_reg [MAX_POINTS];
    logic [COMP_W-1:0] aval_reg [MAX_POINTS];
    logic [IW-1:0]     ccnt_reg, acnt_reg;

    in_item_t          item_reg;
    logic [POS_W-1:0]  j_reg;
    logic [IW-1:0]     idx_reg;
    trk_t              ctrk_reg, atrk_reg;
    seg_t              cseg_reg, aseg_reg;
    logic [ST_W-1:0]   put_st_reg;
    logic [COMP_IW-1:0] comp_reg;
    logic [POS_W-1:0]  rem_reg;
    logic [COMP_W-1:0] qsh_reg;
    logic [SW-1:0]     step_reg;
    logic [TLEN_W-1:0] len_reg;
    logic              neg_reg;
    logic [COMP_W-1:0] base_reg;
    logic [COMP_W-1:0] res_reg [NCOMP];
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [IX-1:0]     ix;
    logic              is_alpha;
    logic [IW-1:0]     n_sel;
    logic [POS_W-1:0]  pos_sel;
    logic              in_list;
    logic              match;
    logic              full;
    logic [IW-1:0]     qmax;
    logic [POS_W-1:0]  j_next;
    seg_t              seg_cur;
    logic [COMP_W-1:0] a_c, b_c, mag;
    logic [POS_W-1:0]  t_c;
    logic [2*POS_W+COMP_W-POS_W-1:0] prod;
    logic [POS_W:0]    rem2;
    logic              ge;
    logic [TLEN_W-1:0] tlen;
    trk_t              trk_zero;
    out_item_t         out_next;

    assign ix       = idx_reg[IX-1:0];
    assign is_alpha = (item_reg.cmd == CMD_PUT_ALPHA);
    assign n_sel    = is_alpha ? acnt_reg : ccnt_reg;
    assign in_list  = (idx_reg < n_sel);
    assign pos_sel  = in_list ? (is_alpha ? apos_reg[ix] : cpos_reg[ix]) : '0;
    assign match    = in_list && (pos_sel == item_reg.position);
    assign full     = (n_sel >= IW'(MAX_POINTS));
    assign qmax     = (ccnt_reg > acnt_reg) ? ccnt_reg : acnt_reg;
    assign trk_zero = '0;

    always_comb
    begin
        if (in_item.position < min_pos_reg)
            j_next = min_pos_reg;
        else if (in_item.position > max_pos_reg)
            j_next = max_pos_reg;
        else
            j_next = in_item.position;
    end

    // Operand selection for the component in work.
    always_comb
    begin
        seg_cur = (comp_reg == COMP_IW'(NCOMP - 1)) ? aseg_reg : cseg_reg;
        case (comp_reg)
            3'd0:    begin a_c = seg_cur.a_val[15:0];  b_c = seg_cur.b_val[15:0];  end
            3'd1:    begin a_c = seg_cur.a_val[31:16]; b_c = seg_cur.b_val[31:16]; end
            3'd2:    begin a_c = seg_cur.a_val[47:32]; b_c = seg_cur.b_val[47:32]; end
            3'd3:    begin a_c = seg_cur.a_val[63:48]; b_c = seg_cur.b_val[63:48]; end
            default: begin a_c = seg_cur.a_val[15:0];  b_c = seg_cur.b_val[15:0];  end
        endcase
        mag  = (b_c >= a_c) ? (b_c - a_c) : (a_c - b_c);
        t_c  = j_reg - seg_cur.a_pos;
        prod = (POS_W + COMP_W)'(mag) * (POS_W + COMP_W)'(t_c);
    end

    assign rem2 = {rem_reg, qsh_reg[COMP_W-1]};
    assign ge   = ({1'b0, rem2} >= {1'b0, len_reg});
    assign tlen = (max_pos_reg >= min_pos_reg)
                  ? ({1'b0, max_pos_reg} - {1'b0, min_pos_reg} + TLEN_W'(1)) : '0;

    // Result item of the finished command.
    always_comb
    begin
        out_next = '0;
        case (item_reg.cmd) inside
            CMD_PUT_COLOR, CMD_PUT_ALPHA: out_next.status = put_st_reg;
            CMD_QUERY:
            begin
                out_next.table_length = tlen;
                if (ctrk_reg.cnt != 2'd2)
                    out_next.status = ST_FEW;
                else
                begin
                    out_next.status    = ST_OK;
                    out_next.out_red   = res_reg[0];
                    out_next.out_green = res_reg[1];
                    out_next.out_blue  = res_reg[2];
                    out_next.out_alpha = (atrk_reg.cnt == 2'd2) ? res_reg[4] : res_reg[3];
                end
            end
            default: out_next.status = ST_OK;
        endcase
    end

    assign sts.new_cmd   = in_item.cmd;
    assign sts.put_end   = !(in_list && pos_sel < item_reg.position);
    assign sts.q_end     = (idx_reg >= qmax);
    assign sts.div_last  = (step_reg == SW'(COMP_W - 1));
    assign sts.last_comp = (comp_reg == COMP_IW'(NCOMP - 1));
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Control state: configuration, fill counts and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pos_reg   <= MIN_POS_RESET;
            max_pos_reg   <= MAX_POS_RESET;
            ccnt_reg      <= '0;
            acnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MIN_POS: min_pos_reg <= cfg_data;
                    CFG_MAX_POS: max_pos_reg <= cfg_data;
                    default:     ;
                endcase
            end
            if (cmd.put_commit && !match && !full)
            begin
                if (is_alpha)
                    acnt_reg <= acnt_reg + IW'(1);
                else
                    ccnt_reg <= ccnt_reg + IW'(1);
            end
            if (cmd.res_load && item_reg.cmd == CMD_CLEAR)
            begin
                ccnt_reg <= '0;
                acnt_reg <= '0;
            end
            if (cmd.res_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Sorted point tables: a new point shifts the tail up by one entry.
    always_ff @(posedge clk)
    begin
        if (cmd.put_commit && !is_alpha)
        begin
            if (match)
                cval_reg[ix] <= {item_reg.alpha_in, item_reg.blue_in,
                                 item_reg.green_in, item_reg.red_in};
            else if (!full)
            begin
                for (int k = 1; k < MAX_POINTS; k++)
                begin
                    if (32'(idx_reg) < k && k <= 32'(ccnt_reg))
                    begin
                        cpos_reg[k] <= cpos_reg[k-1];
                        cval_reg[k] <= cval_reg[k-1];
                    end
                end
                cpos_reg[ix] <= item_reg.position;
                cval_reg[ix] <= {item_reg.alpha_in, item_reg.blue_in,
                                 item_reg.green_in, item_reg.red_in};
            end
        end
        if (cmd.put_commit && is_alpha)
        begin
            if (match)
                aval_reg[ix] <= item_reg.alpha_in;
            else if (!full)
            begin
                for (int k = 1; k < MAX_POINTS; k++)
                begin
                    if (32'(idx_reg) < k && k <= 32'(acnt_reg))
                    begin
                        apos_reg[k] <= apos_reg[k-1];
                        aval_reg[k] <= aval_reg[k-1];
                    end
                end
                apos_reg[ix] <= item_reg.position;
                aval_reg[ix] <= item_reg.alpha_in;
            end
        end
    end

    // Item, scan, divider and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
            j_reg    <= j_next;
            idx_reg  <= '0;
            ctrk_reg <= trk_zero;
            atrk_reg <= trk_zero;
        end
        if (cmd.put_step)
            idx_reg <= idx_reg + IW'(1);
        if (cmd.put_commit)
            put_st_reg <= (!match && full) ? ST_FULL : ST_OK;
        if (cmd.q_step)
        begin
            if (idx_reg < ccnt_reg)
                ctrk_reg <= trk_update(ctrk_reg, cpos_reg[ix], cval_reg[ix],
                                       min_pos_reg, max_pos_reg, j_reg);
            if (idx_reg < acnt_reg)
                atrk_reg <= trk_update(atrk_reg, apos_reg[ix],
                                       {{(VAL_W-COMP_W){1'b0}}, aval_reg[ix]},
                                       min_pos_reg, max_pos_reg, j_reg);
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.seg_load)
        begin
            cseg_reg <= seg_select(ctrk_reg, ctrk_reg.first_val,
                                   min_pos_reg, max_pos_reg, j_reg);
            aseg_reg <= seg_select(atrk_reg, '0, min_pos_reg, max_pos_reg, j_reg);
            comp_reg <= '0;
        end
        if (cmd.mul)
        begin
            rem_reg  <= prod[COMP_W+POS_W-1:COMP_W];
            qsh_reg  <= prod[COMP_W-1:0];
            step_reg <= '0;
            len_reg  <= {1'b0, seg_cur.b_pos} - {1'b0, seg_cur.a_pos} + TLEN_W'(1);
            neg_reg  <= (b_c < a_c);
            base_reg <= a_c;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= ge ? POS_W'({1'b0, rem2} - {1'b0, len_reg}) : rem2[POS_W-1:0];
            qsh_reg  <= {qsh_reg[COMP_W-2:0], ge};
            step_reg <= step_reg + SW'(1);
        end
        if (cmd.comp_store)
        begin
            res_reg[comp_reg] <= neg_reg ? (base_reg - qsh_reg) : (base_reg + qsh_reg);
            comp_reg          <= comp_reg + COMP_IW'(1);
        end
        if (cmd.res_load)
            out_reg <= out_next;
    end

endmodule

// ----- rtl/core/piecewise_linear_color_ramp.sv -----
// Top level of the piecewise-linear RGBA color ramp.
//
// Usage: items arrive on in_item under in_valid/in_stall. An item either puts a color
// point, puts an alpha point, clears both point tables, or queries a table position.
// Every item gives exactly one result item on out_item under out_valid/out_stall.
// min_pos and max_pos are to be written on the cfg port (cfg_ready is always high) only while the
// block is idle; the block itself does not enforce this.
// A put scans the stored points below the new position and then inserts the point or
// replaces its value. A clear goes straight to its result. A query scans the stored
// points of both tables, then takes five components (red, green, blue, color alpha and
// ramp alpha) through one shared multiplier and a 16-step serial divider.
// One item is in work at a time; in_stall is high from acceptance until its result is
// written into the output register, so the next item may be taken while that result
// still waits for the receiver.
// A stalled receiver holds the result in the output register; a finished item then
// waits in its final step until the register frees.
// Reset clears both point counts, restores min_pos to 0 and max_pos to 99, and empties
// the output register. Point entries are not cleared; only entries below the count are
// ever read.
module piecewise_linear_color_ramp #(
    parameter int MAX_POINTS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  crp_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output crp_pkg::out_item_t                out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [crp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crp_pkg::POS_W-1:0]         cfg_data
);
    import crp_pkg::*;

    crp_cmd_t cmd;
    crp_sts_t sts;

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    crp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    crp_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- rtl/core/crp_checker.sv -----
// Port-level checks of the color ramp and the bind that attaches them.
module crp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input crp_pkg::out_item_t out_item,
    input logic               out_valid,
    input logic               out_stall
);
    import crp_pkg::*;

    // A held result must not change or vanish.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // One item at a time: acceptance always closes the input for the next cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item accepted back to back");

    // Too few color points gives an all-zero color.
    a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_FEW |->
            out_item.out_red == '0 && out_item.out_green == '0 &&
            out_item.out_blue == '0 && out_item.out_alpha == '0)
        else $error("nonzero color with too few points");

    // A full-table put reports no table length.
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_FULL |-> out_item.table_length == '0)
        else $error("table length on put result");

endmodule

bind piecewise_linear_color_ramp crp_checker u_crp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall)
);

// ----- verif/piecewise_linear_color_ramp_tb.sv -----
// Self-checking testbench for the piecewise-linear RGBA color ramp.
module piecewise_linear_color_ramp_tb;
    import crp_pkg::*;

    // Keeps its own copy of the point tables and range registers, predicts the
    // result of every accepted item and checks results in order.
    class ramp_scoreboard;
        bit [POS_W-1:0] color_pos[16];
        bit [VAL_W-1:0] color_val[16];
        int             color_cnt;
        bit [POS_W-1:0] alpha_pos[16];
        bit [VAL_W-1:0] alpha_val[16];
        int             alpha_cnt;
        bit [POS_W-1:0] lo_pos;
        bit [POS_W-1:0] hi_pos;
        out_item_t      expected_results[$];
        int             mismatches;

        function new();
            lo_pos     = MIN_POS_RESET;
            hi_pos     = MAX_POS_RESET;
            color_cnt  = 0;
            alpha_cnt  = 0;
            mismatches = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
            if (idx == CFG_MIN_POS)
                lo_pos = data;
            else
                hi_pos = data;
        endfunction

        // Sorted insert; a point at a held position only replaces the value.
        function automatic logic [ST_W-1:0] insert_point(ref bit [POS_W-1:0] pa[16],
                                                         ref bit [VAL_W-1:0] va[16],
                                                         ref int n, input bit [POS_W-1:0] p,
                                                         input bit [VAL_W-1:0] v);
            int i;
            i = 0;
            while (i < n && pa[i] < p)
                i++;
            if (i < n && pa[i] == p)
            begin
                va[i] = v;
                return ST_OK;
            end
            if (n >= 16)
                return ST_FULL;
            for (int k = n; k > i; k--)
            begin
                pa[k] = pa[k-1];
                va[k] = va[k-1];
            end
            pa[i] = p;
            va[i] = v;
            n++;
            return ST_OK;
        endfunction

        // Gathers the in-range points, padded out to both ends of the range.
        function automatic int extend_points(input bit [POS_W-1:0] pa[16],
                                             input bit [VAL_W-1:0] va[16], input int n,
                                             input bit zero_head,
                                             output bit [POS_W-1:0] ep[18],
                                             output bit [VAL_W-1:0] ev[18],
                                             output int in_range);
            int k;
            int first;
            int last;
            k        = 0;
            first    = 0;
            last     = 0;
            in_range = 0;
            for (int i = 0; i < n; i++)
            begin
                if (pa[i] >= lo_pos && pa[i] <= hi_pos)
                begin
                    if (in_range == 0)
                        first = i;
                    last = i;
                    in_range++;
                end
            end
            if (in_range == 0)
                return 0;
            if (pa[first] != lo_pos)
            begin
                ep[k] = lo_pos;
                ev[k] = zero_head ? '0 : va[first];
                k++;
            end
            for (int i = first; i <= last; i++)
            begin
                ep[k] = pa[i];
                ev[k] = va[i];
                k++;
            end
            if (pa[last] != hi_pos)
            begin
                ep[k] = hi_pos;
                ev[k] = va[last];
                k++;
            end
            return k;
        endfunction

        // Interpolates one 16-bit component; the quotient truncates toward zero.
        function automatic bit [COMP_W-1:0] interpolate(input bit [POS_W-1:0] ep[18],
                                                        input bit [VAL_W-1:0] ev[18],
                                                        input int k, input int j,
                                                        input int shift);
            int     i;
            longint a;
            longint b;
            longint t;
            longint len;
            longint r;
            i = 0;
            if (j >= ep[k-1])
                i = k - 2;
            else
                while (i + 2 < k && ep[i+1] <= j)
                    i++;
            a   = (ev[i] >> shift) & 64'hFFFF;
            b   = (ev[i+1] >> shift) & 64'hFFFF;
            t   = j - longint'(ep[i]);
            len = longint'(ep[i+1]) - longint'(ep[i]) + 1;
            r   = a + (b - a) * t / len;
            return r[COMP_W-1:0];
        endfunction

        function void note_input(in_item_t it);
            out_item_t      res;
            bit [POS_W-1:0] ep[18];
            bit [VAL_W-1:0] ev[18];
            int             k;
            int             m;
            int             j;
            res = '0;
            case (it.cmd)
                CMD_PUT_COLOR:
                    res.status = insert_point(color_pos, color_val, color_cnt, it.position,
                        {it.alpha_in, it.blue_in, it.green_in, it.red_in});
                CMD_PUT_ALPHA:
                    res.status = insert_point(alpha_pos, alpha_val, alpha_cnt, it.position,
                        {48'd0, it.alpha_in});
                CMD_CLEAR:
                begin
                    color_cnt = 0;
                    alpha_cnt = 0;
                end
                default:
                begin
                    res.table_length = (hi_pos >= lo_pos) ? TLEN_W'(hi_pos - lo_pos + 1) : '0;
                    k = extend_points(color_pos, color_val, color_cnt, 1'b0, ep, ev, m);
                    if (m < 2)
                        res.status = ST_FEW;
                    else
                    begin
                        j = it.position;
                        if (j < lo_pos)
                            j = lo_pos;
                        if (j > hi_pos)
                            j = hi_pos;
                        res.out_red   = interpolate(ep, ev, k, j, 0);
                        res.out_green = interpolate(ep, ev, k, j, 16);
                        res.out_blue  = interpolate(ep, ev, k, j, 32);
                        res.out_alpha = interpolate(ep, ev, k, j, 48);
                        k = extend_points(alpha_pos, alpha_val, alpha_cnt, 1'b1, ep, ev, m);
                        if (m >= 2)
                            res.out_alpha = interpolate(ep, ev, k, j, 0);
                    end
                end
            endcase
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (expected_results.size() == 0)
            begin
                $error("result item arrived with nothing expected");
                mismatches++;
                return;
            end
            exp_r = expected_results.pop_front();
            compare_field("status", exp_r.status, got.status);
            compare_field("out_red", exp_r.out_red, got.out_red);
            compare_field("out_green", exp_r.out_green, got.out_green);
            compare_field("out_blue", exp_r.out_blue, got.out_blue);
            compare_field("out_alpha", exp_r.out_alpha, got.out_alpha);
            compare_field("table_length", exp_r.table_length, got.table_length);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [POS_W-1:0]      cfg_data;

    ramp_scoreboard sb;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             hold_cycles;

    piecewise_linear_color_ramp u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver samples results at the edge and picks its next stall at random.
    // A pending hold keeps the stall high for a long stretch so that the block
    // backs up and holds its own input off.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall   <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Offers one item and returns at the edge where it is taken. The valid is left
    // high so that a following item goes out back to back.
    task automatic send_item(in_item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(it);
    endtask

    function automatic in_item_t make_item(logic [CMD_W-1:0] cmd, int pos,
                                           logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                                           logic [COMP_W-1:0] b, logic [COMP_W-1:0] a);
        in_item_t it;
        it.cmd      = cmd;
        it.position = POS_W'(pos);
        it.red_in   = r;
        it.green_in = g;
        it.blue_in  = b;
        it.alpha_in = a;
        return it;
    endfunction

    function automatic logic [COMP_W-1:0] random_component();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return COMP_W'($urandom);
        endcase
    endfunction

    // Mostly puts and queries near the covered range, with the odd clear and some
    // positions anywhere in the 12-bit space.
    function automatic in_item_t random_item();
        int          sel;
        int          pos;
        int          wlo;
        int          whi;
        logic [CMD_W-1:0] cmd;
        sel = $urandom_range(99);
        if (sel < 35)
            cmd = CMD_PUT_COLOR;
        else if (sel < 55)
            cmd = CMD_PUT_ALPHA;
        else if (sel < 58)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_QUERY;
        wlo = (sb.lo_pos > 3) ? sb.lo_pos - 3 : 0;
        whi = (sb.hi_pos < 4092) ? sb.hi_pos + 3 : 4095;
        if ($urandom_range(99) < 75 && wlo <= whi)
            pos = $urandom_range(whi, wlo);
        else
            pos = $urandom_range(4095);
        return make_item(cmd, pos, random_component(), random_component(),
                         random_component(), random_component());
    endfunction

    // Waits until every result is in, then writes one range register.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int data);
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= POS_W'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_register(idx, POS_W'(data));
        cfg_valid <= 1'b0;
    endtask

    task automatic set_range(int lo, int hi);
        write_register(CFG_MIN_POS, lo);
        write_register(CFG_MAX_POS, hi);
    endtask

    task automatic run_random(int count);
        repeat (count)
            send_item(random_item());
    endtask

    // Directed part at the reset range 0..99: empty tables, extremes of the
    // components, replacement, the alpha ramp, queries outside the range and a
    // point that lies beyond max_pos.
    task automatic run_directed();
        send_item(make_item(CMD_QUERY, 10, '0, '0, '0, '0));
        send_item(make_item(CMD_PUT_COLOR, 0, '1, '0, '1, '0));
        send_item(make_item(CMD_QUERY, 50, '0, '0, '0, '0));
        send_item(make_item(CMD_PUT_COLOR, 99, '0, '1, '0, '1));
        send_item(make_item(CMD_QUERY, 0, '0, '0, '0, '0));
        send_item(make_item(CMD_QUERY, 99, '0, '0, '0, '0));
        send_item(make_item(CMD_PUT_COLOR, 50, 16'h8000, 16'h1234, 16'hFFFF, 16'h0001));
        send_item(make_item(CMD_PUT_COLOR, 50, 16'h0001, 16'hFFFE, 16'h4000, 16'hC000));
        send_item(make_item(CMD_QUERY, 49, '0, '0, '0, '0));
        send_item(make_item(CMD_QUERY, 75, '0, '0, '0, '0));
        send_item(make_item(CMD_QUERY, 4095, '1, '1, '1, '1));
        send_item(make_item(CMD_PUT_ALPHA, 30, '0, '0, '0, '1));
        send_item(make_item(CMD_QUERY, 30, '0, '0, '0, '0));
        send_item(make_item(CMD_PUT_ALPHA, 70, '1, '1, '1, '0));
        send_item(make_item(CMD_QUERY, 20, '0, '0, '0, '0));
        send_item(make_item(CMD_QUERY, 90, '0, '0, '0, '0));
        send_item(make_item(CMD_PUT_ALPHA, 0, '0, '0, '0, 16'h7FFF));
        send_item(make_item(CMD_QUERY, 15, '0, '0, '0, '0));
        send_item(make_item(CMD_PUT_COLOR, 200, '1, '1, '1, '1));
        send_item(make_item(CMD_QUERY, 98, '0, '0, '0, '0));
        send_item(make_item(CMD_CLEAR, 0, '0, '0, '0, '0));
        send_item(make_item(CMD_QUERY, 99, '0, '0, '0, '0));
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        out_stall     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_MIN_POS;
        cfg_data      = '0;
        hold_cycles   = 0;
        send_idle_pct = 25;
        recv_idle_pct = 74;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Sender idles lightly while the receiver stalls most of the time.
        set_range(0, 4095);
        run_random(300);
        set_range(10, 20);
        run_random(250);

        // Roles swapped, including an inverted range and the top of the space.
        send_idle_pct = 74;
        recv_idle_pct = 25;
        set_range(100, 50);
        run_random(120);
        set_range(4000, 4095);
        run_random(250);
        set_range(4095, 4095);
        run_random(40);

        // No idling on either side; the receiver holds off once for a long while.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_range(0, 99);
        hold_cycles = 400;
        run_random(350);
        set_range(0, 0);
        run_random(40);
        set_range(5, 300);
        run_random(300);

        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/crp_pkg.sv
rtl/core/crp_ctrl.sv
rtl/core/crp_dpath.sv
rtl/core/piecewise_linear_color_ramp.sv
rtl/core/crp_checker.sv
verif/piecewise_linear_color_ramp_tb.sv
